// ----- hw/rtl/gtf_pkg.sv -----
// ----------------------------------------------------------------------------
// gtf_pkg
// Shared widths, constants and the sideband record for the GTF modeline pipe.
// ----------------------------------------------------------------------------
`default_nettype none

package gtf_pkg;

  // Divider operand widths and quotient depth (one quotient bit per stage)
  localparam int DIV_NUM_W = 35;
  localparam int DIV_DEN_W = 25;
  localparam int DIV_Q     = 21;
  localparam int DIV_ACC_W = DIV_DEN_W + DIV_Q;

  // Valid input ranges
  localparam int W_MIN = 8;
  localparam int H_MIN = 240;
  localparam int F_MIN = 50;
  localparam int F_MAX = 120;

  // Formula constants
  localparam int K_VB_BASE  = 10000;
  localparam int K_VB_DEN   = 20000;
  localparam int K_HB_OFS   = 300000;
  localparam int K_HB_NUM   = 30;
  localparam int K_HB_DEN   = 70;
  localparam int K_VB_MUL   = 11;
  localparam int K_PCT_RND  = 50;
  localparam int K_RECIP100 = 5243;   // ceil(2^19 / 100), exact for x < 6000
  localparam int K_RECIP_SH = 19;

  // ceil(2^41 / 1000), exact divide by 1000 for any 32-bit numerator
  localparam logic [31:0] K_RECIP1000    = 32'd2199023256;
  localparam int          K_RECIP1000_SH = 41;

  // Transaction record carried alongside the divider stages
  typedef struct packed {
    logic        err;
    logic [11:0] w;
    logic [10:0] h;
    logic [6:0]  f;
    logic [11:0] vbl;
    logic [18:0] vfreq;
    logic [10:0] hbl;
    logic [12:0] tot;
    logic [15:0] hss;
    logic [15:0] hse;
    logic [15:0] hbe;
  } side_t;

endpackage

`default_nettype wire

// ----- hw/rtl/gtf_modeline_timing_calc.sv -----
// ----------------------------------------------------------------------------
// gtf_modeline_timing_calc
// Integer GTF modeline calculator: width, height, refresh in; timings out.
// ----------------------------------------------------------------------------
// Pipeline: 2 * 21 divider stages + 10 stage registers.
// Throughput: one transaction per cycle unless out_stall holds a result; both dividers are fully pipelined,
// one quotient bit per stage, and the divide by 1000 is a reciprocal multiply.
// Stall: the whole pipe holds while a result waits on out_stall.
// Reset: synchronous, active low, clears every valid bit; data is not reset.
`default_nettype none

module gtf_modeline_timing_calc (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [11:0] in_width,
  input  wire logic [10:0] in_height,
  input  wire logic [6:0]  in_refresh_hz,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [30:0]      out_pixel_clock_khz,
  output logic [15:0]      out_hsync_start,
  output logic [15:0]      out_hsync_end,
  output logic [15:0]      out_hblank_end,
  output logic [15:0]      out_vsync_start,
  output logic [15:0]      out_vsync_end,
  output logic [15:0]      out_vblank_end,
  output logic             out_range_error
);

  localparam int NW = gtf_pkg::DIV_NUM_W;
  localparam int DW = gtf_pkg::DIV_DEN_W;

  // Advance every stage unless a finished result is being held
  logic en;
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  // ---- S0: capture and range check
  logic           s0_valid_r;
  gtf_pkg::side_t s0_side_r, s0_side_nxt;

  always_comb begin
    s0_side_nxt     = '0;
    s0_side_nxt.w   = in_width;
    s0_side_nxt.h   = in_height;
    s0_side_nxt.f   = in_refresh_hz;
    s0_side_nxt.err = (in_width < 12'(gtf_pkg::W_MIN)) ||
                      (in_height < 11'(gtf_pkg::H_MIN)) ||
                      (in_refresh_hz < 7'(gtf_pkg::F_MIN)) ||
                      (in_refresh_hz > 7'(gtf_pkg::F_MAX));
  end

  // ---- S1: vertical blank numerator and denominator
  logic           s1_valid_r;
  gtf_pkg::side_t s1_side_r;
  logic [NW-1:0]  s1_num_r, s1_num_nxt;
  logic [DW-1:0]  s1_den_r, s1_den_nxt;

  always_comb begin
    logic [23:0] prod;
    logic [23:0] f24;
    f24        = 24'(s0_side_r.f);
    prod       = (24'(s0_side_r.h) + 24'd1) * 24'(gtf_pkg::K_VB_MUL) * f24;
    s1_num_nxt = NW'(prod + 24'(gtf_pkg::K_VB_BASE) - 24'd5 * f24
                 - ((f24 + 24'd1) >> 1));
    s1_den_nxt = DW'(24'(gtf_pkg::K_VB_DEN) - 24'(gtf_pkg::K_VB_MUL) * f24);
  end

  logic           d1_valid;
  logic [gtf_pkg::DIV_Q-1:0] d1_quo;
  gtf_pkg::side_t d1_side;

  gtf_div u_div_vbl (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (s1_valid_r),
    .in_num   (s1_num_r),
    .in_den   (s1_den_r),
    .in_side  (s1_side_r),
    .out_valid(d1_valid),
    .out_quo  (d1_quo),
    .out_side (d1_side)
  );

  // ---- S2: total vertical lines
  logic           s2_valid_r;
  gtf_pkg::side_t s2_side_r, s2_side_nxt;

  always_comb begin
    s2_side_nxt     = d1_side;
    s2_side_nxt.vbl = 12'(d1_side.h) + 12'd1 + d1_quo[11:0];
  end

  // ---- S3: line rate
  logic           s3_valid_r;
  gtf_pkg::side_t s3_side_r, s3_side_nxt;

  always_comb begin
    s3_side_nxt       = s2_side_r;
    s3_side_nxt.vfreq = 19'(s2_side_r.vbl) * 19'(s2_side_r.f);
  end

  // ---- S4: horizontal blank duty terms
  logic           s4_valid_r;
  gtf_pkg::side_t s4_side_r;
  logic [22:0]    s4_a_r, s4_a_nxt;
  logic [DW-1:0]  s4_den_r, s4_den_nxt;

  always_comb begin
    s4_a_nxt   = 23'(25'(gtf_pkg::K_HB_NUM) * 25'(s3_side_r.vfreq)
                 - 25'(gtf_pkg::K_HB_OFS));
    s4_den_nxt = DW'(gtf_pkg::K_HB_DEN) * DW'(s3_side_r.vfreq) + DW'(gtf_pkg::K_HB_OFS);
  end

  // ---- S5: horizontal blank numerator
  logic           s5_valid_r;
  gtf_pkg::side_t s5_side_r;
  logic [NW-1:0]  s5_num_r, s5_num_nxt;
  logic [DW-1:0]  s5_den_r;

  assign s5_num_nxt = NW'(s4_side_r.w) * NW'(s4_a_r);

  logic           d2_valid;
  logic [gtf_pkg::DIV_Q-1:0] d2_quo;
  gtf_pkg::side_t d2_side;

  gtf_div u_div_hbl (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (s5_valid_r),
    .in_num   (s5_num_r),
    .in_den   (s5_den_r),
    .in_side  (s5_side_r),
    .out_valid(d2_valid),
    .out_quo  (d2_quo),
    .out_side (d2_side)
  );

  // ---- S6: round blank to a multiple of 16, total pixels per line
  logic           s6_valid_r;
  gtf_pkg::side_t s6_side_r, s6_side_nxt;

  always_comb begin
    logic [11:0] rnd;
    rnd             = d2_quo[11:0] + 12'd8;
    s6_side_nxt     = d2_side;
    s6_side_nxt.hbl = {rnd[10:4], 4'b0000};
    s6_side_nxt.tot = 13'(d2_side.w) + {2'b00, rnd[10:4], 4'b0000};
  end

  // ---- S7: pixel clock numerator and horizontal sync positions
  logic           s7_valid_r;
  gtf_pkg::side_t s7_side_r, s7_side_nxt;
  logic [31:0]    s7_num_r, s7_num_nxt;

  always_comb begin
    logic [26:0] pct;
    logic [15:0] hse;
    s7_num_nxt      = 32'(s6_side_r.tot) * 32'(s6_side_r.vfreq);
    // (tot + 50) / 100 by reciprocal multiply
    pct             = (27'(s6_side_r.tot) + 27'(gtf_pkg::K_PCT_RND))
                    * 27'(gtf_pkg::K_RECIP100);
    hse             = 16'(s6_side_r.w) + 16'(s6_side_r.hbl >> 1) - 16'd1;
    s7_side_nxt     = s6_side_r;
    s7_side_nxt.hse = hse;
    s7_side_nxt.hbe = 16'(s6_side_r.tot) - 16'd1;
    s7_side_nxt.hss = hse - {5'b0, pct[gtf_pkg::K_RECIP_SH +: 8], 3'b000};
  end

  // ---- S8: pixel clock, numerator / 1000 by reciprocal multiply
  logic           s8_valid_r;
  gtf_pkg::side_t s8_side_r;
  logic [63:0]    s8_prod_r, s8_prod_nxt;

  assign s8_prod_nxt = {32'b0, s7_num_r} * {32'b0, gtf_pkg::K_RECIP1000};

  // ---- valid bits: advance together, drop to bubble when input idle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
      s4_valid_r <= 1'b0;
      s5_valid_r <= 1'b0;
      s6_valid_r <= 1'b0;
      s7_valid_r <= 1'b0;
      s8_valid_r <= 1'b0;
      out_valid  <= 1'b0;
    end else if (en) begin
      s0_valid_r <= in_valid;
      s1_valid_r <= s0_valid_r;
      s2_valid_r <= d1_valid;
      s3_valid_r <= s2_valid_r;
      s4_valid_r <= s3_valid_r;
      s5_valid_r <= s4_valid_r;
      s6_valid_r <= d2_valid;
      s7_valid_r <= s6_valid_r;
      s8_valid_r <= s7_valid_r;
      out_valid  <= s8_valid_r;
    end
  end

  // ---- data registers; output zeroed for out-of-range requests
  always_ff @(posedge clk) begin
    if (en) begin
      s0_side_r <= s0_side_nxt;
      s1_side_r <= s0_side_r;
      s1_num_r  <= s1_num_nxt;
      s1_den_r  <= s1_den_nxt;
      s2_side_r <= s2_side_nxt;
      s3_side_r <= s3_side_nxt;
      s4_side_r <= s3_side_r;
      s4_a_r    <= s4_a_nxt;
      s4_den_r  <= s4_den_nxt;
      s5_side_r <= s4_side_r;
      s5_num_r  <= s5_num_nxt;
      s5_den_r  <= s4_den_r;
      s6_side_r <= s6_side_nxt;
      s7_side_r <= s7_side_nxt;
      s7_num_r  <= s7_num_nxt;
      s8_side_r <= s7_side_r;
      s8_prod_r <= s8_prod_nxt;
      out_range_error <= s8_side_r.err;
      if (s8_side_r.err) begin
        out_pixel_clock_khz <= '0;
        out_hsync_start     <= '0;
        out_hsync_end       <= '0;
        out_hblank_end      <= '0;
        out_vsync_start     <= '0;
        out_vsync_end       <= '0;
        out_vblank_end      <= '0;
      end else begin
        out_pixel_clock_khz <= 31'(s8_prod_r >> gtf_pkg::K_RECIP1000_SH);
        out_hsync_start     <= s8_side_r.hss;
        out_hsync_end       <= s8_side_r.hse;
        out_hblank_end      <= s8_side_r.hbe;
        out_vsync_start     <= 16'(s8_side_r.h);
        out_vsync_end       <= 16'(s8_side_r.h) + 16'd3;
        out_vblank_end      <= 16'(s8_side_r.vbl) - 16'd1;
      end
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/gtf_div.sv -----
// ----------------------------------------------------------------------------
// gtf_div
// Pipelined restoring divider, one quotient bit per stage, with sideband.
// ----------------------------------------------------------------------------
`default_nettype none

module gtf_div (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           en,
  input  wire logic                           in_valid,
  input  wire logic [gtf_pkg::DIV_NUM_W-1:0]  in_num,
  input  wire logic [gtf_pkg::DIV_DEN_W-1:0]  in_den,
  input  wire gtf_pkg::side_t                 in_side,
  output logic                                out_valid,
  output logic [gtf_pkg::DIV_Q-1:0]           out_quo,
  output gtf_pkg::side_t                      out_side
);

  localparam int Q = gtf_pkg::DIV_Q;
  localparam int A = gtf_pkg::DIV_ACC_W;

  logic [Q-1:0]                   valid_r;
  logic [gtf_pkg::DIV_NUM_W-1:0]  rem_r [Q];
  logic [gtf_pkg::DIV_NUM_W-1:0]  rem_nxt [Q];
  logic [gtf_pkg::DIV_DEN_W-1:0]  den_r [Q];
  logic [Q-1:0]                   quo_r [Q];
  logic [Q-1:0]                   quo_nxt [Q];
  gtf_pkg::side_t                 side_r [Q];

  // Each stage tries den << (Q-1-s) against the running remainder
  always_comb begin
    for (int s = 0; s < Q; s++) begin
      logic [gtf_pkg::DIV_NUM_W-1:0] rem_in;
      logic [gtf_pkg::DIV_DEN_W-1:0] den_in;
      logic [Q-1:0]                  quo_in;
      logic [A:0]                    trial;
      rem_in = (s == 0) ? in_num : rem_r[(s == 0) ? 0 : s - 1];
      den_in = (s == 0) ? in_den : den_r[(s == 0) ? 0 : s - 1];
      quo_in = (s == 0) ? '0 : quo_r[(s == 0) ? 0 : s - 1];
      trial  = {{(A + 1 - gtf_pkg::DIV_NUM_W){1'b0}}, rem_in}
             - ({{(Q + 1){1'b0}}, den_in} << (Q - 1 - s));
      if (!trial[A]) begin
        rem_nxt[s] = trial[gtf_pkg::DIV_NUM_W-1:0];
        quo_nxt[s] = quo_in | (Q'(1) << (Q - 1 - s));
      end else begin
        rem_nxt[s] = rem_in;
        quo_nxt[s] = quo_in;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (en) begin
      valid_r <= {valid_r[Q-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int s = 0; s < Q; s++) begin
        rem_r[s] <= rem_nxt[s];
        quo_r[s] <= quo_nxt[s];
        den_r[s]  <= (s == 0) ? in_den  : den_r[(s == 0) ? 0 : s - 1];
        side_r[s] <= (s == 0) ? in_side : side_r[(s == 0) ? 0 : s - 1];
      end
    end
  end

  assign out_valid = valid_r[Q-1];
  assign out_quo   = quo_r[Q-1];
  assign out_side  = side_r[Q-1];

endmodule

`default_nettype wire
